// ===== design/rgf_pkg.sv =====
// Shared types, constants and a width helper for the two-circle radial gradient unit.
package rgf_pkg;

  localparam int TABLE_SIZE_DEF    = 1024;
  localparam int FRACTION_BITS_DEF = 4;
  localparam int PIXEL_W           = 12;
  localparam int INDEX_W           = 10;
  localparam int CFG_W             = 16;
  localparam int ADDR_W            = 5;
  localparam int DATA_W            = 32;
  localparam int REG_IDX_W         = 3;
  localparam int Q_DEPTH           = 4;

  localparam logic [REG_IDX_W-1:0] REG_START_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_END_X        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_Y        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_RADIUS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_RADIUS   = 3'd5;

  typedef struct packed {
    logic signed [CFG_W-1:0] start_x;
    logic signed [CFG_W-1:0] start_y;
    logic signed [CFG_W-1:0] end_x;
    logic signed [CFG_W-1:0] end_y;
    logic [CFG_W-1:0]        start_radius;
    logic [CFG_W-1:0]        end_radius;
  } cfg_regs_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Width of a signed length in half-fraction units, covering pixel centres and doubled registers.
  function automatic int coord_width(input int f);
    return ((13 + f > 17) ? 13 + f : 17) + 2;
  endfunction

endpackage

// ===== design/rgf_in_if.sv =====
// Request channel carrying one pixel coordinate.
interface rgf_in_if;
  logic                         valid;
  logic                         ready;
  logic [rgf_pkg::PIXEL_W-1:0]  pixel_x;
  logic [rgf_pkg::PIXEL_W-1:0]  pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== design/rgf_out_if.sv =====
// Result channel carrying one colour-table index and its painted flag.
interface rgf_out_if;
  logic                         valid;
  logic                         ready;
  logic [rgf_pkg::INDEX_W-1:0]  table_index;
  logic                         painted;

  modport source (output valid, output table_index, output painted, input ready);
  modport sink (input valid, input table_index, input painted, output ready);
endinterface

// ===== design/rgf_mul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
module rgf_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [WA-1:0]     a,
  input  logic signed [WB-1:0]     b,
  output logic signed [WA+WB-1:0]  p
);
  localparam int HA = (WA + 1) / 2;
  localparam int HB = (WB + 1) / 2;
  localparam int SW = WA + WB;

  logic [WA-1:0] am;
  logic [WB-1:0] bm;
  logic [HA+HB-1:0]           ll_r;
  logic [HA+WB-HB-1:0]        lh_r;
  logic [WA-HA+HB-1:0]        hl_r;
  logic [WA-HA+WB-HB-1:0]     hh_r;
  logic                       neg_r;
  logic [SW-1:0]              sum;

  assign am = a[WA-1] ? WA'(-a) : WA'(a);
  assign bm = b[WB-1] ? WB'(-b) : WB'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= am[HA-1:0] * bm[HB-1:0];
      lh_r  <= am[HA-1:0] * bm[WB-1:HB];
      hl_r  <= am[WA-1:HA] * bm[HB-1:0];
      hh_r  <= am[WA-1:HA] * bm[WB-1:HB];
      neg_r <= a[WA-1] ^ b[WB-1];
    end
  end

  assign sum = (SW'(hh_r) << (HA + HB)) + (SW'(lh_r) << HB) + (SW'(hl_r) << HA) + SW'(ll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg_r ? -$signed(sum) : $signed(sum);
    end
  end
endmodule

// ===== design/rgf_fifo.sv =====
// Short queue between the front and back halves of the gradient unit.
module rgf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rgf_pkg::Q_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [WIDTH-1:0]    din,
  input  logic                pop,
  output logic [WIDTH-1:0]    dout,
  output rgf_pkg::q_status_t  status
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout         = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == CW'(DEPTH));
  assign status.empty = (cnt_r == '0);
endmodule

// ===== design/rgf_front.sv =====
// Front half: takes pixel requests and forms the quadratic coefficients a, b and c.
module rgf_front #(
  parameter int FRACTION_BITS = rgf_pkg::FRACTION_BITS_DEF,
  localparam int WP = rgf_pkg::coord_width(FRACTION_BITS),
  localparam int WQ = 2 * WP + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rgf_in_if.sink               in_ch,
  input  rgf_pkg::cfg_regs_t   cfg,
  input  logic                 q_full,
  output logic                 push,
  output logic [3*WQ-1:0]      push_data
);
  logic signed [WP-1:0] sx2, sy2, ex2, ey2, r0w, r1w, cx, cy, dr;
  logic [WP-1:0]        pcx, pcy;
  logic signed [WP-1:0] px_nxt, py_nxt, px_r, py_r;
  logic signed [2*WP-1:0] m_pxcx_r, m_pycy_r, m_r0dr_r, m_pxpx_r, m_pypy_r;
  logic signed [2*WP-1:0] m_r0r0_r, m_cxcx_r, m_cycy_r, m_drdr_r;
  logic signed [WQ-1:0] a_r, b_r, c_r;
  logic v1_r, v2_r, v3_r;
  logic en;

  assign sx2 = {{(WP-17){cfg.start_x[15]}}, cfg.start_x, 1'b0};
  assign sy2 = {{(WP-17){cfg.start_y[15]}}, cfg.start_y, 1'b0};
  assign ex2 = {{(WP-17){cfg.end_x[15]}}, cfg.end_x, 1'b0};
  assign ey2 = {{(WP-17){cfg.end_y[15]}}, cfg.end_y, 1'b0};
  assign r0w = {{(WP-17){1'b0}}, cfg.start_radius, 1'b0};
  assign r1w = {{(WP-17){1'b0}}, cfg.end_radius, 1'b0};
  assign cx  = ex2 - sx2;
  assign cy  = ey2 - sy2;
  assign dr  = r1w - r0w;

  // Pixel centre sits half a pixel into the cell.
  assign pcx    = (WP'(in_ch.pixel_x) << (FRACTION_BITS + 1)) | (WP'(1) << FRACTION_BITS);
  assign pcy    = (WP'(in_ch.pixel_y) << (FRACTION_BITS + 1)) | (WP'(1) << FRACTION_BITS);
  assign px_nxt = $signed(pcx) - sx2;
  assign py_nxt = $signed(pcy) - sy2;

  assign en          = !(v3_r && q_full);
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      m_pxcx_r <= px_r * cx;
      m_pycy_r <= py_r * cy;
      m_r0dr_r <= r0w * dr;
      m_pxpx_r <= px_r * px_r;
      m_pypy_r <= py_r * py_r;
      m_r0r0_r <= r0w * r0w;
      m_cxcx_r <= cx * cx;
      m_cycy_r <= cy * cy;
      m_drdr_r <= dr * dr;
      a_r      <= WQ'(m_cxcx_r) + WQ'(m_cycy_r) - WQ'(m_drdr_r);
      b_r      <= WQ'(m_pxcx_r) + WQ'(m_pycy_r) + WQ'(m_r0dr_r);
      c_r      <= WQ'(m_pxpx_r) + WQ'(m_pypy_r) - WQ'(m_r0r0_r);
    end
  end

  assign push      = v3_r && !q_full;
  assign push_data = {a_r, b_r, c_r};
endmodule

// ===== design/rgf_back.sv =====
// Back half: solves the quadratic, picks the root, checks the radius and scales to an index.
module rgf_back #(
  parameter int TABLE_SIZE    = rgf_pkg::TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = rgf_pkg::FRACTION_BITS_DEF,
  localparam int WP = rgf_pkg::coord_width(FRACTION_BITS),
  localparam int WQ = 2 * WP + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgf_pkg::cfg_regs_t   cfg,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [3*WQ-1:0]      q_data,
  rgf_out_if.source            out_ch
);
  localparam int WD  = 2 * WQ + 1;
  localparam int WR  = WQ;
  localparam int WN1 = WQ + 1;
  localparam int WM  = WN1 + WP;
  localparam int WS  = WM + 1;
  localparam int QB  = $clog2(TABLE_SIZE);
  localparam int QI  = (QB > rgf_pkg::INDEX_W) ? QB : rgf_pkg::INDEX_W;
  localparam int WNN = WQ + QB + 3;
  localparam logic [WNN-1:0] SCALE = WNN'(2 * (TABLE_SIZE - 1));

  typedef enum logic [1:0] {MD_ZERO, MD_SAT, MD_DIV} mode_t;

  function automatic logic pos_ratio(input logic signed [WS-1:0] q,
                                     input logic signed [WN1-1:0] d);
    return ((d > 0) && (q > 0)) || ((d < 0) && (q < 0));
  endfunction

  logic en;
  logic signed [WP-1:0] r0s, r1s, drs;

  assign r0s = {{(WP-17){1'b0}}, cfg.start_radius, 1'b0};
  assign r1s = {{(WP-17){1'b0}}, cfg.end_radius, 1'b0};
  assign drs = r1s - r0s;

  logic out_v_r;
  logic [rgf_pkg::INDEX_W-1:0] out_idx_r;
  logic out_pnt_r;

  assign en    = !out_v_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  // Dequeue stage.
  logic v0_r;
  logic signed [WQ-1:0] a0_r, b0_r, c0_r;

  // Discriminant products.
  logic signed [2*WQ-1:0] bb, ac;
  logic v1_r, v2_r;
  logic signed [WQ-1:0] a1_r, b1_r, c1_r, a2_r, b2_r, c2_r;

  rgf_mul #(.WA(WQ), .WB(WQ)) u_mul_bb (.clk(clk), .en(en), .a(b0_r), .b(b0_r), .p(bb));
  rgf_mul #(.WA(WQ), .WB(WQ)) u_mul_ac (.clk(clk), .en(en), .a(a0_r), .b(c0_r), .p(ac));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= q_pop;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r <= q_data[3*WQ-1 -: WQ];
      b0_r <= q_data[2*WQ-1 -: WQ];
      c0_r <= q_data[WQ-1:0];
      a1_r <= a0_r;
      b1_r <= b0_r;
      c1_r <= c0_r;
      a2_r <= a1_r;
      b2_r <= b1_r;
      c2_r <= c1_r;
    end
  end

  // Square root pipeline, one result bit per stage.
  logic signed [WD-1:0] dsc;
  logic                 dsc_neg;
  logic [2*WR-1:0]      rad;

  assign dsc     = WD'(bb) - WD'(ac);
  assign dsc_neg = dsc[WD-1];
  assign rad     = dsc_neg ? '0 : dsc[2*WR-1:0];

  logic                 sq_v_r    [0:WR];
  logic [2*WR-1:0]      sq_rad_r  [0:WR];
  logic [WR+1:0]        sq_rem_r  [0:WR];
  logic [WR-1:0]        sq_root_r [0:WR];
  logic signed [WQ-1:0] sq_a_r    [0:WR];
  logic signed [WQ-1:0] sq_b_r    [0:WR];
  logic signed [WQ-1:0] sq_c_r    [0:WR];
  logic                 sq_neg_r  [0:WR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= rad;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_a_r[0]    <= a2_r;
      sq_b_r[0]    <= b2_r;
      sq_c_r[0]    <= c2_r;
      sq_neg_r[0]  <= dsc_neg;
    end
  end

  for (genvar k = 0; k < WR; k++) begin : g_sqrt
    logic [WR+1:0] rem_sh;
    logic [WR+1:0] trial;
    logic          take;

    assign rem_sh = {sq_rem_r[k][WR-1:0], sq_rad_r[k][2*WR-1 -: 2]};
    assign trial  = {sq_root_r[k], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= take ? rem_sh - trial : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][WR-2:0], take};
        sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
        sq_a_r[k+1]    <= sq_a_r[k];
        sq_b_r[k+1]    <= sq_b_r[k];
        sq_c_r[k+1]    <= sq_c_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
      end
    end
  end

  // Both roots as numerators over a.
  logic signed [WN1-1:0] bx, rx, nbig_nxt, nsmall_nxt;
  logic                  a_pos;

  assign bx    = WN1'(sq_b_r[WR]);
  assign rx    = $signed({1'b0, sq_root_r[WR]});
  assign a_pos = !sq_a_r[WR][WQ-1] && (sq_a_r[WR] != '0);
  assign nbig_nxt   = a_pos ? bx + rx : bx - rx;
  assign nsmall_nxt = a_pos ? bx - rx : bx + rx;

  logic v4_r, v5_r, v6_r;
  logic signed [WQ-1:0]  a4_r, b4_r, c4_r, a5_r, b5_r, c5_r, a6_r, b6_r, c6_r;
  logic signed [WN1-1:0] nbig4_r, nsmall4_r, nbig5_r, nsmall5_r, nbig6_r, nsmall6_r;
  logic neg4_r, neg5_r, neg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_v_r[WR];
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r      <= sq_a_r[WR];
      b4_r      <= sq_b_r[WR];
      c4_r      <= sq_c_r[WR];
      nbig4_r   <= nbig_nxt;
      nsmall4_r <= nsmall_nxt;
      neg4_r    <= sq_neg_r[WR];
      a5_r      <= a4_r;
      b5_r      <= b4_r;
      c5_r      <= c4_r;
      nbig5_r   <= nbig4_r;
      nsmall5_r <= nsmall4_r;
      neg5_r    <= neg4_r;
      a6_r      <= a5_r;
      b6_r      <= b5_r;
      c6_r      <= c5_r;
      nbig6_r   <= nbig5_r;
      nsmall6_r <= nsmall5_r;
      neg6_r    <= neg5_r;
    end
  end

  // Radius sign products.
  logic signed [WM-1:0] p_ra, p_bg, p_sm, p_br, p_cd;

  rgf_mul #(.WA(WN1), .WB(WP)) u_mul_ra (.clk(clk), .en(en), .a(WN1'(a4_r)), .b(r0s), .p(p_ra));
  rgf_mul #(.WA(WN1), .WB(WP)) u_mul_bg (.clk(clk), .en(en), .a(nbig4_r), .b(drs), .p(p_bg));
  rgf_mul #(.WA(WN1), .WB(WP)) u_mul_sm (.clk(clk), .en(en), .a(nsmall4_r), .b(drs), .p(p_sm));
  rgf_mul #(.WA(WN1), .WB(WP)) u_mul_br (.clk(clk), .en(en), .a($signed({b4_r, 1'b0})),
                                         .b(r0s), .p(p_br));
  rgf_mul #(.WA(WN1), .WB(WP)) u_mul_cd (.clk(clk), .en(en), .a(WN1'(c4_r)), .b(drs), .p(p_cd));

  // Root choice and paint decision.
  logic signed [WS-1:0]  q0, q1, q2;
  logic signed [WN1-1:0] num7_nxt, den7_nxt, num7_r, den7_r;
  logic                  pnt7_nxt, pnt7_r, v7_r;
  logic                  ok1, ok2;

  assign q0  = WS'(p_br) + WS'(p_cd);
  assign q1  = WS'(p_ra) + WS'(p_bg);
  assign q2  = WS'(p_ra) + WS'(p_sm);
  assign ok1 = pos_ratio(q1, WN1'(a6_r));
  assign ok2 = pos_ratio(q2, WN1'(a6_r));

  always_comb begin
    if (a6_r == '0) begin
      num7_nxt = WN1'(c6_r);
      den7_nxt = $signed({b6_r, 1'b0});
      pnt7_nxt = (b6_r != '0) && pos_ratio(q0, $signed({b6_r, 1'b0}));
    end else begin
      num7_nxt = ok1 ? nbig6_r : nsmall6_r;
      den7_nxt = WN1'(a6_r);
      pnt7_nxt = !neg6_r && (ok1 || ok2);
    end
  end

  // Sign normalization and clamping.
  logic signed [WN1:0] ns, ds;
  mode_t               mode8_nxt, mode8_r;
  logic [WN1-1:0]      n8_r, d8_r;
  logic                pnt8_r, v8_r;

  assign ns = den7_r[WN1-1] ? -(WN1+1)'(num7_r) : (WN1+1)'(num7_r);
  assign ds = den7_r[WN1-1] ? -(WN1+1)'(den7_r) : (WN1+1)'(den7_r);

  always_comb begin
    priority if (!pnt7_r || ns <= 0) begin
      mode8_nxt = MD_ZERO;
    end else if (ns >= ds) begin
      mode8_nxt = MD_SAT;
    end else begin
      mode8_nxt = MD_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num7_r  <= num7_nxt;
      den7_r  <= den7_nxt;
      pnt7_r  <= pnt7_nxt;
      n8_r    <= ns[WN1-1:0];
      d8_r    <= ds[WN1-1:0];
      mode8_r <= mode8_nxt;
      pnt8_r  <= pnt7_r;
    end
  end

  // Rounding divider, one quotient bit per stage.
  logic           dv_v_r    [0:QB];
  logic [WNN-1:0] dv_rem_r  [0:QB];
  logic [WNN-1:0] dv_den_r  [0:QB];
  logic [QB-1:0]  dv_q_r    [0:QB];
  mode_t          dv_mode_r [0:QB];
  logic           dv_pnt_r  [0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0]  <= WNN'(n8_r) * SCALE + WNN'(d8_r);
      dv_den_r[0]  <= WNN'(d8_r) << 1;
      dv_q_r[0]    <= '0;
      dv_mode_r[0] <= mode8_r;
      dv_pnt_r[0]  <= pnt8_r;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int J = QB - 1 - k;
    logic [WNN-1:0] sub;
    logic           take;

    assign sub  = dv_den_r[k] << J;
    assign take = (dv_rem_r[k] >= sub);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1]  <= take ? dv_rem_r[k] - sub : dv_rem_r[k];
        dv_den_r[k+1]  <= dv_den_r[k];
        dv_q_r[k+1]    <= dv_q_r[k] | (QB'(take) << J);
        dv_mode_r[k+1] <= dv_mode_r[k];
        dv_pnt_r[k+1]  <= dv_pnt_r[k];
      end
    end
  end

  logic [QI-1:0] idx_nxt;

  always_comb begin
    unique case (dv_mode_r[QB])
      MD_SAT:  idx_nxt = QI'(TABLE_SIZE - 1);
      MD_DIV:  idx_nxt = QI'(dv_q_r[QB]);
      default: idx_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r <= idx_nxt[rgf_pkg::INDEX_W-1:0];
      out_pnt_r <= dv_pnt_r[QB];
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.table_index = out_idx_r;
  assign out_ch.painted     = out_pnt_r;
endmodule

// ===== design/two_circle_radial_gradient.sv =====
// Top level of the two-circle radial gradient index unit with its register port.
// Throughput is one pixel per cycle when not stalled; front and back pipelines stall
// independently. Most of the pipeline depth lies in the square root stages,
// one per root bit. Reset is synchronous and active low; it clears the valid flags,
// queue pointers and configuration registers, which empties the pipeline.
module two_circle_radial_gradient #(
  parameter int TABLE_SIZE    = rgf_pkg::TABLE_SIZE_DEF,
  parameter int FRACTION_BITS = rgf_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rgf_in_if.sink                       in_ch,
  rgf_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rgf_pkg::ADDR_W-1:0]   paddr,
  input  logic [rgf_pkg::DATA_W-1:0]   pwdata,
  output logic [rgf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  localparam int WP = rgf_pkg::coord_width(FRACTION_BITS);
  localparam int WQ = 2 * WP + 2;

  rgf_pkg::cfg_regs_t            cfg_r;
  logic [rgf_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[rgf_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        rgf_pkg::REG_START_X:      cfg_r.start_x      <= pwdata[rgf_pkg::CFG_W-1:0];
        rgf_pkg::REG_START_Y:      cfg_r.start_y      <= pwdata[rgf_pkg::CFG_W-1:0];
        rgf_pkg::REG_END_X:        cfg_r.end_x        <= pwdata[rgf_pkg::CFG_W-1:0];
        rgf_pkg::REG_END_Y:        cfg_r.end_y        <= pwdata[rgf_pkg::CFG_W-1:0];
        rgf_pkg::REG_START_RADIUS: cfg_r.start_radius <= pwdata[rgf_pkg::CFG_W-1:0];
        rgf_pkg::REG_END_RADIUS:   cfg_r.end_radius   <= pwdata[rgf_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rgf_pkg::REG_START_X:      prdata = rgf_pkg::DATA_W'(cfg_r.start_x);
      rgf_pkg::REG_START_Y:      prdata = rgf_pkg::DATA_W'(cfg_r.start_y);
      rgf_pkg::REG_END_X:        prdata = rgf_pkg::DATA_W'(cfg_r.end_x);
      rgf_pkg::REG_END_Y:        prdata = rgf_pkg::DATA_W'(cfg_r.end_y);
      rgf_pkg::REG_START_RADIUS: prdata = rgf_pkg::DATA_W'(cfg_r.start_radius);
      rgf_pkg::REG_END_RADIUS:   prdata = rgf_pkg::DATA_W'(cfg_r.end_radius);
      default:                   prdata = '0;
    endcase
  end

  logic               q_push;
  logic               q_pop;
  logic [3*WQ-1:0]    q_din;
  logic [3*WQ-1:0]    q_dout;
  rgf_pkg::q_status_t q_stat;

  rgf_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .q_full    (q_stat.full),
    .push      (q_push),
    .push_data (q_din)
  );

  rgf_fifo #(.WIDTH(3 * WQ), .DEPTH(rgf_pkg::Q_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .din    (q_din),
    .pop    (q_pop),
    .dout   (q_dout),
    .status (q_stat)
  );

  rgf_back #(.TABLE_SIZE(TABLE_SIZE), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_stat.empty),
    .q_pop   (q_pop),
    .q_data  (q_dout),
    .out_ch  (out_ch)
  );

  a_unpainted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.painted |-> out_ch.table_index == '0)
    else $error("Unpainted pixel carries a nonzero table index.");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("Result valid right after reset.");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("Queue reports full and empty at once.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_stat.full)
    else $error("Request side stalled while the queue has room.");
endmodule

// ===== dv/two_circle_radial_gradient_tb.sv =====
// Self-checking testbench for the two-circle radial gradient index unit.
module two_circle_radial_gradient_tb;
  import rgf_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct packed {
    logic [INDEX_W-1:0] table_index;
    logic               painted;
  } shade_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  rgf_in_if  pixel_bus ();
  rgf_out_if shade_bus ();

  two_circle_radial_gradient u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(pixel_bus.sink), .out_ch(shade_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  cfg_regs_t gradient_cfg;
  shade_t    pending_shades[$];
  int        error_count = 0;
  int        quiet_cycles = 0;
  bit        idling_on = 1'b1;
  bit        holdoff_req = 1'b0;

  initial begin
    pixel_bus.valid   = 1'b0;
    pixel_bus.pixel_x = '0;
    pixel_bus.pixel_y = '0;
    shade_bus.ready   = 1'b0;
  end

  function automatic bit ratio_positive(longint q, longint d);
    return (d > 0 && q > 0) || (d < 0 && q < 0);
  endfunction

  function automatic logic [INDEX_W-1:0] scale_to_table(longint num, longint den);
    longint n, d;
    n = num;
    d = den;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (n <= 0) return '0;
    if (n >= d) return INDEX_W'(TABLE_SIZE_DEF - 1);
    return INDEX_W'((2 * n * (TABLE_SIZE_DEF - 1) + d) / (2 * d));
  endfunction

  function automatic shade_t predict_shade(logic [PIXEL_W-1:0] x, logic [PIXEL_W-1:0] y);
    longint one, half, sx, sy, ex, ey, r0, dr, px, py, cx, cy, qa, qb, qc, num, den, root;
    logic signed [127:0] disc;
    logic [127:0] trial;
    shade_t res;
    one  = longint'(1) << (FRACTION_BITS_DEF + 1);
    half = longint'(1) << FRACTION_BITS_DEF;
    sx = 2 * longint'(gradient_cfg.start_x);
    sy = 2 * longint'(gradient_cfg.start_y);
    ex = 2 * longint'(gradient_cfg.end_x);
    ey = 2 * longint'(gradient_cfg.end_y);
    r0 = 2 * longint'({1'b0, gradient_cfg.start_radius});
    dr = 2 * longint'({1'b0, gradient_cfg.end_radius}) - r0;
    px = longint'({1'b0, x}) * one + half - sx;
    py = longint'({1'b0, y}) * one + half - sy;
    cx = ex - sx;
    cy = ey - sy;
    qa = cx * cx + cy * cy - dr * dr;
    qb = px * cx + py * cy + r0 * dr;
    qc = px * px + py * py - r0 * r0;
    res = '0;
    if (qa == 0) begin
      if (qb == 0) return res;
      num = qc;
      den = 2 * qb;
      if (!ratio_positive(den * r0 + qc * dr, den)) return res;
    end else begin
      disc = 128'(signed'(qb)) * 128'(signed'(qb)) - 128'(signed'(qa)) * 128'(signed'(qc));
      if (disc < 0) return res;
      root = 0;
      for (int bitpos = 63; bitpos >= 0; bitpos--) begin
        trial = 128'(root | (longint'(1) << bitpos));
        if (trial * trial <= disc) root = longint'(trial);
      end
      num = (qa > 0) ? qb + root : qb - root;
      if (!ratio_positive(r0 * qa + num * dr, qa)) num = (qa > 0) ? qb - root : qb + root;
      if (!ratio_positive(r0 * qa + num * dr, qa)) return res;
      den = qa;
    end
    res.table_index = scale_to_table(num, den);
    res.painted = 1'b1;
    return res;
  endfunction

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    psel   = 1'b1;
    pwrite = 1'b1;
    paddr  = ADDR_W'({idx, 2'b00});
    pwdata = {16'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_START_X:      gradient_cfg.start_x = value;
      REG_START_Y:      gradient_cfg.start_y = value;
      REG_END_X:        gradient_cfg.end_x = value;
      REG_END_Y:        gradient_cfg.end_y = value;
      REG_START_RADIUS: gradient_cfg.start_radius = value;
      REG_END_RADIUS:   gradient_cfg.end_radius = value;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    pixel_bus.valid = 1'b0;
    while (pending_shades.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_gradient(logic [CFG_W-1:0] sx, logic [CFG_W-1:0] sy,
                               logic [CFG_W-1:0] ex, logic [CFG_W-1:0] ey,
                               logic [CFG_W-1:0] r0, logic [CFG_W-1:0] r1);
    wait_idle();
    cfg_write(REG_START_X, sx);
    cfg_write(REG_START_Y, sy);
    cfg_write(REG_END_X, ex);
    cfg_write(REG_END_Y, ey);
    cfg_write(REG_START_RADIUS, r0);
    cfg_write(REG_END_RADIUS, r1);
  endtask

  task automatic send_pixel(logic [PIXEL_W-1:0] x, logic [PIXEL_W-1:0] y);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      pixel_bus.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    pixel_bus.valid   = 1'b1;
    pixel_bus.pixel_x = x;
    pixel_bus.pixel_y = y;
    @(posedge clk);
    while (!pixel_bus.ready) @(posedge clk);
    pending_shades.push_back(predict_shade(x, y));
  endtask

  function automatic logic [CFG_W-1:0] near_coord();
    return CFG_W'($urandom_range(0, 4095 * 16));
  endfunction

  task automatic load_random_gradient();
    if ($urandom_range(0, 3) == 0)
      load_gradient(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                    CFG_W'($urandom), CFG_W'($urandom));
    else
      load_gradient(near_coord(), near_coord(), near_coord(), near_coord(),
                    CFG_W'($urandom_range(0, 16000)), CFG_W'($urandom_range(0, 40000)));
  endtask

  task automatic test_directed();
    // Everything zero makes the quadratic degenerate with a zero linear term.
    send_pixel('0, '0);
    send_pixel('1, '1);
    load_gradient(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16000);
    send_pixel('0, '0);
    send_pixel(12'd100, 12'd200);
    send_pixel('1, '1);
    // Equal center distance and radius growth makes the square term vanish.
    load_gradient(16'd0, 16'd0, 16'd1600, 16'd0, 16'd0, 16'd1600);
    send_pixel(12'd10, 12'd0);
    send_pixel(12'd4000, 12'd5);
    send_pixel(12'd0, 12'd4000);
    // Small circles far apart leave off-axis pixels without a real root.
    load_gradient(16'd1600, 16'd1600, 16'd3200, 16'd1600, 16'd16, 16'd32);
    send_pixel(12'd150, 12'd2000);
    send_pixel(12'd150, 12'd100);
    send_pixel(12'd250, 12'd100);
    send_pixel(12'd50, 12'd100);
    load_gradient(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 16'd0);
    send_pixel('0, '1);
    send_pixel('1, '0);
    send_pixel(12'd2048, 12'd2048);
    load_gradient(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'd0, 16'hffff);
    send_pixel('0, '0);
    send_pixel(12'd3000, 12'd1000);
    load_gradient(16'd32000, 16'd32000, 16'd32000, 16'd32000, 16'd8000, 16'd100);
    send_pixel(12'd2000, 12'd2000);
    send_pixel(12'd2100, 12'd1900);
    wait_idle();
    // The unmapped register index must leave all settings alone.
    cfg_write(REG_UNMAPPED, 16'hffff);
    send_pixel(12'd1999, 12'd2001);
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      load_random_gradient();
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 1) == 0)
          send_pixel(PIXEL_W'($urandom), PIXEL_W'($urandom));
        else
          send_pixel(PIXEL_W'(gradient_cfg.end_x >>> 4) + PIXEL_W'($urandom_range(0, 63)),
                     PIXEL_W'(gradient_cfg.end_y >>> 4) + PIXEL_W'($urandom_range(0, 63)));
      end
    end
  endtask

  task automatic test_backpressure();
    load_random_gradient();
    holdoff_req = 1'b1;
    for (int i = 0; i < 120; i++) send_pixel(PIXEL_W'($urandom), PIXEL_W'($urandom));
  endtask

  initial begin
    gradient_cfg = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(6, 40);
    test_backpressure();
    idling_on = 1'b0;
    test_random(2, 40);
    wait_idle();
    if (error_count == 0) begin
      $display("two_circle_radial_gradient verification clean");
    end else begin
      $display("two_circle_radial_gradient verification failed");
    end
    $finish;
  end

  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        shade_bus.ready = 1'b0;
        hold = 0;
        while (hold < HOLDOFF_CYCLES) begin
          @(negedge clk);
          hold++;
        end
      end else if (idling_on && rst_n && $urandom_range(0, 5) == 0) begin
        shade_bus.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      shade_bus.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    shade_t want;
    if (shade_bus.valid && shade_bus.ready) begin
      if (pending_shades.size() == 0) begin
        $error("unexpected result: table_index %0d painted %0d",
               shade_bus.table_index, shade_bus.painted);
        error_count++;
      end else begin
        want = pending_shades.pop_front();
        if (shade_bus.table_index !== want.table_index) begin
          $error("table_index expected %0d actual %0d", want.table_index, shade_bus.table_index);
          error_count++;
        end
        if (shade_bus.painted !== want.painted) begin
          $error("painted expected %0d actual %0d", want.painted, shade_bus.painted);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pixel_bus.valid && pixel_bus.ready) || (shade_bus.valid && shade_bus.ready) ||
        psel || pending_shades.size() == 0) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("two_circle_radial_gradient verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
design/rgf_pkg.sv
design/rgf_in_if.sv
design/rgf_out_if.sv
design/rgf_mul.sv
design/rgf_fifo.sv
design/rgf_front.sv
design/rgf_back.sv
design/two_circle_radial_gradient.sv
dv/two_circle_radial_gradient_tb.sv
